@@ design/fhfa_pkg.sv @@
// ----------------------------------------------------------------------------
// fhfa_pkg: shared types and constants of the free hole fit allocator
// Field widths, operation, status and policy codes, and the control group
// that the sequencer hands to the fit compare unit.
// ----------------------------------------------------------------------------
package fhfa_pkg;

   localparam int MAX_HOLES_DEF   = 64;
   localparam int OFFSET_BITS_DEF = 32;

   localparam int START_BITS    = 32;
   localparam int LEN_BITS      = 32;
   localparam int PLACE_BITS    = 32;
   localparam int HOLES_BITS    = 7;
   localparam int POLICY_BITS   = 2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Operation codes of an input item.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_PLACE = 1'b1;

   // Fit policy codes; the unused code behaves as first fit.
   localparam logic [POLICY_BITS-1:0] POLICY_BEST  = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_WORST = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_FIRST = 2'd2;

   // Register index of the fit policy register.
   localparam logic REG_FIT_POLICY = 1'b0;

   typedef enum logic [1:0] {
      STATUS_PLACED = 2'd0,
      STATUS_NO_FIT = 2'd1,
      STATUS_ADDED  = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic clear;   // forget the current best candidate
      logic sample;  // a candidate hole is on the inputs this cycle
   } fit_ctrl_type;

endpackage

@@ design/free_hole_fit_allocator_core.sv @@
// ----------------------------------------------------------------------------
// free_hole_fit_allocator_core: free hole table with best, worst or first fit
// Keeps up to MAX_HOLES free holes in a RAM and places requests into them
// with one shared fit compare unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one operation per transfer: op 0 appends a freed
// hole (req_hole_start, req_length) at the end of the table, op 1 asks to
// place a request of req_length bytes. Every transfer yields exactly one
// transfer on the rsp channel with a status, the placement offset (zero
// unless placed) and the number of holes held afterwards.
// An accepted add goes through the done state to the output register. A
// placement scans the table one hole per cycle through the RAM read port
// into the fit compare unit. When the chosen hole empties it is removed and
// the later entries are copied down one per cycle through the same port.
// req_ready is high only while no operation is in progress. A result waits
// in the output register while the receiver stalls; the next operation is
// still accepted and runs, and only its final hand-off waits for the slot.
// Reset empties the table and selects best fit; the RAM itself is not
// cleared, since only entries below the hole count are ever read.
// The fit_policy register (0 best, 1 worst, 2 or 3 first fit) sits at
// address 0 of the csr port. The user must see that it is written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module free_hole_fit_allocator_core #(
   parameter int MAX_HOLES   = fhfa_pkg::MAX_HOLES_DEF,
   parameter int OFFSET_BITS = fhfa_pkg::OFFSET_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [fhfa_pkg::START_BITS-1:0]      req_hole_start,
   input  logic [fhfa_pkg::LEN_BITS-1:0]        req_length,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output fhfa_pkg::status_type                 rsp_status,
   output logic [fhfa_pkg::PLACE_BITS-1:0]      rsp_place_offset,
   output logic [fhfa_pkg::HOLES_BITS-1:0]      rsp_holes_in_use,
   // Configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fhfa_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [fhfa_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [fhfa_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import fhfa_pkg::*;

   localparam int IDX_BITS  = $clog2(MAX_HOLES);
   localparam int CNT_BITS  = $clog2(MAX_HOLES + 1);
   localparam int WORD_BITS = OFFSET_BITS + LEN_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [POLICY_BITS-1:0] policy_ff, policy_in;
   logic [LEN_BITS-1:0]    need_ff, need_in;
   logic [CNT_BITS-1:0]    issue_ff, issue_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]    rd_idx_ff, rd_idx_in;
   status_type             res_status_ff, res_status_in;
   logic [OFFSET_BITS-1:0] res_offset_ff, res_offset_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [PLACE_BITS-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [HOLES_BITS-1:0]  rsp_holes_ff, rsp_holes_in;

   // RAM ports
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   logic [WORD_BITS-1:0]   wr_data;
   logic                   rd_en;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [WORD_BITS-1:0]   rd_data;

   // Fit unit
   fit_ctrl_type           fit_ctrl;
   logic                   fit_found;
   logic [IDX_BITS-1:0]    fit_best_idx;
   logic [LEN_BITS-1:0]    fit_best_size;
   logic [OFFSET_BITS-1:0] fit_best_off;

   logic                   req_xfer;
   logic                   csr_write;
   logic                   out_free;
   logic [LEN_BITS-1:0]    new_size;
   logic [OFFSET_BITS-1:0] new_off;

   fhfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_HOLES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fhfa_fit_unit #(
      .MAX_HOLES   (MAX_HOLES),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_fit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fit_ctrl),
      .policy    (policy_ff),
      .need      (need_ff),
      .cand_idx  (rd_idx_ff),
      .cand_size (rd_data[LEN_BITS-1:0]),
      .cand_off  (rd_data[WORD_BITS-1:LEN_BITS]),
      .found     (fit_found),
      .best_idx  (fit_best_idx),
      .best_size (fit_best_size),
      .best_off  (fit_best_off)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Update of the chosen hole: the offset wraps at the offset width.
   assign new_size = fit_best_size - need_ff;
   assign new_off  = fit_best_off + OFFSET_BITS'(need_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      policy_in     = policy_ff;
      need_in       = need_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_holes_in  = rsp_holes_ff;

      wr_en    = 1'b0;
      wr_addr  = rd_idx_ff;
      wr_data  = rd_data;
      rd_en    = 1'b0;
      rd_addr  = issue_ff[IDX_BITS-1:0];
      fit_ctrl = '{clear: 1'b0, sample: 1'b0};

      if (csr_write && (csr_paddr[2] == REG_FIT_POLICY)) begin
         policy_in = csr_pwdata[POLICY_BITS-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               res_offset_in = '0;
               need_in       = req_length;
               if (req_op == OP_ADD) begin
                  if (count_ff >= CNT_BITS'(MAX_HOLES)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = count_ff[IDX_BITS-1:0];
                     wr_data       = {OFFSET_BITS'(req_hole_start), req_length};
                     count_in      = count_ff + CNT_BITS'(1);
                     res_status_in = STATUS_ADDED;
                  end
                  state_in = ST_DONE;
               end else begin
                  issue_in       = '0;
                  fit_ctrl.clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Read hole i while the fit unit judges hole i - 1.
            rd_en           = (issue_ff < count_ff);
            rd_valid_in     = rd_en;
            rd_idx_in       = issue_ff[IDX_BITS-1:0];
            fit_ctrl.sample = rd_valid_ff;
            if (rd_en) begin
               issue_in = issue_ff + CNT_BITS'(1);
            end else if (!rd_valid_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (!fit_found) begin
               res_status_in = STATUS_NO_FIT;
               state_in      = ST_DONE;
            end else begin
               res_status_in = STATUS_PLACED;
               res_offset_in = fit_best_off;
               if (new_size != '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = fit_best_idx;
                  wr_data  = {new_off, new_size};
                  state_in = ST_DONE;
               end else begin
                  // The hole is used up: copy the later entries down.
                  issue_in = CNT_BITS'(fit_best_idx) + CNT_BITS'(1);
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // Read entry j + 1 while the entry j read last cycle goes to j - 1.
            rd_en       = (issue_ff < count_ff);
            rd_valid_in = rd_en;
            rd_idx_in   = issue_ff[IDX_BITS-1:0];
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - IDX_BITS'(1);
               wr_data = rd_data;
            end
            if (rd_en) begin
               issue_in = issue_ff + CNT_BITS'(1);
            end else if (!rd_valid_ff) begin
               count_in = count_ff - CNT_BITS'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_offset_in = PLACE_BITS'(res_offset_ff);
               rsp_holes_in  = HOLES_BITS'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         policy_ff    <= POLICY_BEST;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         policy_ff    <= policy_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      need_ff       <= need_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_holes_ff  <= rsp_holes_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_place_offset = rsp_offset_ff;
   assign rsp_holes_in_use = rsp_holes_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_FIT_POLICY) ?
                       CSR_DATA_BITS'(policy_ff) : '0;

   // The table never holds more holes than it has room for.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_HOLES))
      else $error("hole count exceeds table size");

   // An accepted operation keeps the request side closed in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request accepted while an operation is in progress");

   // Only a placement reports a nonzero offset.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_PLACED)) |-> (rsp_offset_ff == '0))
      else $error("nonzero offset on a result that is not a placement");

   // The scan only reads the table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !wr_en)
      else $error("table written during a scan");

endmodule

@@ design/fhfa_ram.sv @@
// ----------------------------------------------------------------------------
// fhfa_ram: generic simple dual-port RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module fhfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fhfa_fit_unit.sv @@
// ----------------------------------------------------------------------------
// fhfa_fit_unit: shared fit compare unit
// Takes one candidate hole per cycle and keeps the best one seen so far
// under the selected fit policy. Ties keep the earlier (lower) index.
// ----------------------------------------------------------------------------
module fhfa_fit_unit #(
   parameter int MAX_HOLES   = fhfa_pkg::MAX_HOLES_DEF,
   parameter int OFFSET_BITS = fhfa_pkg::OFFSET_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fhfa_pkg::fit_ctrl_type               ctrl,
   input  logic [fhfa_pkg::POLICY_BITS-1:0]     policy,
   input  logic [fhfa_pkg::LEN_BITS-1:0]        need,
   input  logic [$clog2(MAX_HOLES)-1:0]         cand_idx,
   input  logic [fhfa_pkg::LEN_BITS-1:0]        cand_size,
   input  logic [OFFSET_BITS-1:0]               cand_off,
   output logic                                 found,
   output logic [$clog2(MAX_HOLES)-1:0]         best_idx,
   output logic [fhfa_pkg::LEN_BITS-1:0]        best_size,
   output logic [OFFSET_BITS-1:0]               best_off
);
   import fhfa_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_HOLES);

   logic                found_ff, found_in;
   logic [IDX_BITS-1:0] best_idx_ff, best_idx_in;
   logic [LEN_BITS-1:0] best_size_ff, best_size_in;
   logic [OFFSET_BITS-1:0] best_off_ff, best_off_in;
   logic                fits;
   logic                better;
   logic                take;

   always_comb begin
      fits = (cand_size >= need);
      case (policy)
         POLICY_BEST:  better = (cand_size < best_size_ff);
         POLICY_WORST: better = (cand_size > best_size_ff);
         default:      better = (cand_off < best_off_ff);
      endcase
      take = ctrl.sample && fits && (!found_ff || better);

      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      best_off_in  = best_off_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in     = 1'b1;
         best_idx_in  = cand_idx;
         best_size_in = cand_size;
         best_off_in  = cand_off;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
      best_off_ff  <= best_off_in;
   end

   assign found     = found_ff;
   assign best_idx  = best_idx_ff;
   assign best_size = best_size_ff;
   assign best_off  = best_off_ff;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the free hole fit allocator core
// Drives hole adds and placement requests through the request channel and
// checks every result transfer against a cycle-free model of the hole table.
// The run sweeps all fit policy codes, fills and empties the table, and
// stalls both channels at random.
// ----------------------------------------------------------------------------
module tb_top;
   import fhfa_pkg::*;

   // The spare policy code is expected to behave as first fit.
   localparam logic [POLICY_BITS-1:0]   POLICY_SPARE    = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] FIT_POLICY_ADDR = CSR_ADDR_BITS'(4 * REG_FIT_POLICY);
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 230;
   localparam int TARGET_WINDOW   = 120;
   // A placement over a full table plus a shift-down of every entry.
   localparam int PLACE_LATENCY   = 2 * MAX_HOLES_DEF + 5;
   localparam int PRESSURE_START  = 6000;
   localparam int PRESSURE_CYCLES = 400;

   typedef struct {
      status_type             status;
      logic [PLACE_BITS-1:0]  place;
      logic [HOLES_BITS-1:0]  holes;
   } alloc_outcome_type;

   // -------------------------------------------------------------------------
   // Model of the hole table together with the queue of outcomes still owed
   // by the block. note_request() advances the model by one accepted request,
   // check_response() retires the oldest outcome against a result transfer.
   // -------------------------------------------------------------------------
   class hole_table_model_type;
      logic [PLACE_BITS-1:0]  offsets [MAX_HOLES_DEF];
      logic [LEN_BITS-1:0]    sizes [MAX_HOLES_DEF];
      int unsigned            count;
      logic [POLICY_BITS-1:0] policy;
      alloc_outcome_type      pending_outcomes [$];
      int unsigned            mismatches;
      int unsigned            n_placed, n_missed, n_added, n_full;

      function new();
         count      = 0;
         policy     = POLICY_BEST;
         mismatches = 0;
         n_placed   = 0;
         n_missed   = 0;
         n_added    = 0;
         n_full     = 0;
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("%s", what);
      endfunction

      // Index of the hole the current policy picks, or -1 when none fits.
      function int choose_hole(logic [LEN_BITS-1:0] need);
         int pick;
         pick = -1;
         for (int i = 0; i < count; i++) begin
            if (sizes[i] < need) continue;
            if (pick < 0) pick = i;
            else begin
               case (policy)
                  POLICY_BEST:  if (sizes[i] < sizes[pick]) pick = i;
                  POLICY_WORST: if (sizes[i] > sizes[pick]) pick = i;
                  default:      if (offsets[i] < offsets[pick]) pick = i;
               endcase
            end
         end
         return pick;
      endfunction

      function void note_request(logic op, logic [START_BITS-1:0] start,
                                 logic [LEN_BITS-1:0] len);
         alloc_outcome_type o;
         int k;
         o.place = '0;
         if (op == OP_ADD) begin
            if (count >= MAX_HOLES_DEF) o.status = STATUS_FULL;
            else begin
               offsets[count] = start;
               sizes[count]   = len;
               count++;
               o.status = STATUS_ADDED;
            end
         end else begin
            k = choose_hole(len);
            if (k < 0) o.status = STATUS_NO_FIT;
            else begin
               o.place    = offsets[k];
               offsets[k] = offsets[k] + len;
               sizes[k]   = sizes[k] - len;
               if (sizes[k] == '0) begin
                  for (int j = k; j + 1 < count; j++) begin
                     offsets[j] = offsets[j + 1];
                     sizes[j]   = sizes[j + 1];
                  end
                  count--;
               end
               o.status = STATUS_PLACED;
            end
         end
         o.holes = HOLES_BITS'(count);
         pending_outcomes.push_back(o);
      endfunction

      function void check_response(status_type st, logic [PLACE_BITS-1:0] place,
                                   logic [HOLES_BITS-1:0] holes);
         alloc_outcome_type o;
         if (pending_outcomes.size() == 0) begin
            flag($sformatf("result with nothing expected: status %s offset %h holes %0d",
                           st.name(), place, holes));
            return;
         end
         o = pending_outcomes.pop_front();
         case (o.status)
            STATUS_PLACED: n_placed++;
            STATUS_NO_FIT: n_missed++;
            STATUS_ADDED:  n_added++;
            default:       n_full++;
         endcase
         if (st !== o.status || place !== o.place || holes !== o.holes)
            flag($sformatf("result mismatch: expected %s %h %0d, got %s %h %0d",
                           o.status.name(), o.place, o.holes, st.name(), place, holes));
      endfunction
   endclass

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic                       req_op         = OP_ADD;
   logic [START_BITS-1:0]      req_hole_start = '0;
   logic [LEN_BITS-1:0]        req_length     = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   status_type                 rsp_status;
   logic [PLACE_BITS-1:0]      rsp_place_offset;
   logic [HOLES_BITS-1:0]      rsp_holes_in_use;
   logic                       csr_psel       = 1'b0;
   logic                       csr_penable    = 1'b0;
   logic                       csr_pwrite     = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr      = '0;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata     = '0;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   // When set, neither side inserts random idle cycles.
   bit quiet = 1'b0;
   int unsigned policies_written = 0;
   hole_table_model_type free_list = new();

   free_hole_fit_allocator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_hole_start   (req_hole_start),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_place_offset (rsp_place_offset),
      .rsp_holes_in_use (rsp_holes_in_use),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // Result side of the checker. All tb inputs change by nonblocking
   // assignment at the clock edge, so the values seen here are the ones that
   // were present at the edge itself.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         free_list.check_response(rsp_status, rsp_place_offset, rsp_holes_in_use);
   end

   // Receiver. It stalls in random bursts unless the run is in a quiet
   // stretch, and once holds off for a long time so that a finished result
   // blocks the output register and the request channel backs up behind it.
   initial begin : receiver
      int unsigned cycles;
      int unsigned burst;
      bit          pressure_done;
      cycles        = 0;
      pressure_done = 1'b0;
      @(posedge clock);
      forever begin
         if (!pressure_done && cycles >= PRESSURE_START) begin
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            cycles += PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
            cycles += burst;
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
            cycles++;
         end
      end
   end

   // One register access, a setup phase then an access phase, after which the
   // bus idles. A read compares the returned policy against the value given.
   task automatic csr_cycle(input bit is_write, input logic [POLICY_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= FIT_POLICY_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         free_list.policy = value;
         policies_written++;
      end else if (csr_prdata[POLICY_BITS-1:0] !== value) begin
         free_list.flag($sformatf("fit_policy read back %h, expected %h",
                                  csr_prdata[POLICY_BITS-1:0], value));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one request, possibly after a random idle burst, and keeps it on
   // the channel until the transfer happens. Valid is left high on return so
   // that a back-to-back request never drops it.
   task automatic send_item(input logic op, input logic [START_BITS-1:0] start,
                            input logic [LEN_BITS-1:0] len);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_hole_start <= start;
      req_length     <= len;
      do @(posedge clock); while (!req_ready);
      free_list.note_request(op, start, len);
   endtask

   // Drops valid and waits until the block owes no result, so that the
   // policy register may be touched.
   task automatic drain;
      req_valid <= 1'b0;
      while (free_list.pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [POLICY_BITS-1:0] phase_policy [PHASES];
      int unsigned            target;
      int unsigned            r;
      int unsigned            k;
      logic                   g_op;
      logic [START_BITS-1:0]  g_start;
      logic [LEN_BITS-1:0]    g_len;
      logic [LEN_BITS-1:0]    biggest;

      // Every code of the policy field comes in two phases, best fit last, so the
      // spare code is visited twice.
      phase_policy = '{POLICY_WORST, POLICY_FIRST, POLICY_SPARE, POLICY_BEST,
                       POLICY_FIRST, POLICY_WORST, POLICY_SPARE, POLICY_BEST};
      target = 0;
      k      = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset selects best fit.
      csr_cycle(1'b0, POLICY_BEST);

      // Directed part under best fit. A request on the empty table misses;
      // then holes are added that exercise a zero size, an offset that wraps,
      // the largest size and two holes of equal size for the tie rule.
      send_item(OP_PLACE, 32'h0000_0000, 32'h0000_0001);
      send_item(OP_ADD,   32'h0000_0000, 32'h0000_0000);
      send_item(OP_ADD,   32'hFFFF_FFF0, 32'h0000_0020);
      send_item(OP_ADD,   32'h0000_0100, 32'h0000_0050);
      send_item(OP_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_ADD,   32'h0000_0040, 32'h0000_0050);
      // A zero length request fits the zero size hole and removes it.
      send_item(OP_PLACE, 32'hFFFF_FFFF, 32'h0000_0000);
      // The equal holes tie; the lower index wins and empties.
      send_item(OP_PLACE, 32'h0000_0000, 32'h0000_0050);
      // This one pushes the offset of the hole near the top past zero.
      send_item(OP_PLACE, 32'h1234_5678, 32'h0000_0018);
      // A zero length request on holes that are not empty leaves them alone.
      send_item(OP_PLACE, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_PLACE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(OP_PLACE, 32'h0000_0000, 32'h8000_0000);
      send_item(OP_PLACE, 32'h0000_0000, 32'h0000_0008);
      send_item(OP_PLACE, 32'h0000_0000, 32'h0000_0030);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         csr_cycle(1'b1, phase_policy[phase]);
         csr_cycle(1'b0, phase_policy[phase]);
         // One stretch in the middle and the whole last phase run without
         // random idle cycles.
         quiet = (phase == 3) || (phase == PHASES - 1);

         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            // The fill target moves now and then, so the table goes through
            // nearly empty, partly full and full stretches.
            if (item % TARGET_WINDOW == 0) begin
               case ($urandom_range(0, 4))
                  0:       target = 2;
                  1:       target = 8;
                  2:       target = 24;
                  default: target = MAX_HOLES_DEF;
               endcase
            end

            r = $urandom_range(0, 7);
            if (free_list.count < target) g_op = (r != 0) ? OP_ADD : OP_PLACE;
            else g_op = (r < 6) ? OP_PLACE : OP_ADD;

            g_start = $urandom;
            g_len   = $urandom;
            if (free_list.count > 0) k = $urandom_range(0, free_list.count - 1);

            if (g_op == OP_ADD) begin
               r = $urandom_range(0, 9);
               if (r >= 7 && r <= 8) g_start = 32'hFFFF_FFFF - $urandom_range(0, 255);
               else if (r == 9 && free_list.count > 0) g_start = free_list.offsets[k];

               r = $urandom_range(0, 9);
               if (r < 5) g_len = $urandom_range(1, 4096);
               else if (r == 5) g_len = '0;
               else if (r == 8) g_len = 32'hFFFF_FFFF;
               else if (r == 9 && free_list.count > 0) g_len = free_list.sizes[k];
            end else if (free_list.count == 0) begin
               if ($urandom_range(0, 1) == 0) g_len = '0;
            end else begin
               // Mostly lengths that fit a hole, many of them exactly so that
               // the hole empties and the table shifts down.
               r = $urandom_range(0, 9);
               if (r < 4) g_len = free_list.sizes[k];
               else if (r < 6) g_len = $urandom_range(0, free_list.sizes[k]);
               else if (r == 6) g_len = '0;
               else if (r == 8) g_len = 32'hFFFF_FFFF;
               else if (r == 9) begin
                  biggest = '0;
                  for (int i = 0; i < free_list.count; i++)
                     if (free_list.sizes[i] > biggest) biggest = free_list.sizes[i];
                  if (biggest != 32'hFFFF_FFFF) g_len = biggest + 1;
               end
            end

            send_item(g_op, g_start, g_len);
         end
      end

      // Wait for the last results, then give the block time to show any
      // stray transfer.
      drain();
      repeat (PLACE_LATENCY) @(posedge clock);
      if (free_list.pending_outcomes.size() != 0)
         free_list.flag($sformatf("%0d results never arrived",
                                  free_list.pending_outcomes.size()));

      $display("Summary: %0d placed, %0d with no fitting hole, %0d holes added, %0d %s",
               free_list.n_placed, free_list.n_missed, free_list.n_added,
               free_list.n_full, "refused as full.");
      $display("Summary: %0d policy writes, one long receiver hold-off, %0d mismatches.",
               policies_written, free_list.mismatches);
      if (free_list.mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/fhfa_pkg.sv
design/fhfa_ram.sv
design/fhfa_fit_unit.sv
design/free_hole_fit_allocator_core.sv
test/tb_top.sv
